// ----- rtl/thpts_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed heat pump test sequencer package
// Shared types, register map, mode and key codes, and reset values.
// ----------------------------------------------------------------------------
package thpts_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // Register indexes (byte address is 4 * index).
   localparam logic [2:0] REG_RUN_LENGTH   = 3'd0;
   localparam logic [2:0] REG_HEAT_START   = 3'd1;
   localparam logic [2:0] REG_HEAT_STOP    = 3'd2;
   localparam logic [2:0] REG_SAMPLE_PER   = 3'd3;
   localparam logic [2:0] REG_RISE_THRESH  = 3'd4;
   localparam logic [2:0] REG_DELAY_START  = 3'd5;
   localparam logic [2:0] REG_DELAY_STEP   = 3'd6;
   localparam logic [2:0] REG_DELAY_LIMIT  = 3'd7;

   localparam logic [23:0] RST_RUN_LENGTH  = 24'd110000;
   localparam logic [23:0] RST_HEAT_START  = 24'd20000;
   localparam logic [23:0] RST_HEAT_STOP   = 24'd50000;
   localparam logic [15:0] RST_SAMPLE_PER  = 16'd3000;
   localparam logic [11:0] RST_RISE_THRESH = 12'd1;
   localparam logic [13:0] RST_DELAY_START = 14'd2500;
   localparam logic [13:0] RST_DELAY_STEP  = 14'd500;
   localparam logic [13:0] RST_DELAY_LIMIT = 14'd5000;
   localparam logic [13:0] RST_FIRING_DLY  = 14'd2500;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_CONST  = 2'd1;
   localparam logic [1:0] MODE_DYN    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] KEY_NONE   = 2'd0;
   localparam logic [1:0] KEY_ONE    = 2'd1;
   localparam logic [1:0] KEY_TWO    = 2'd2;
   localparam logic [1:0] KEY_CANCEL = 2'd3;

   typedef struct packed {
      logic [23:0] run_length_ms;
      logic [23:0] heat_start_ms;
      logic [23:0] heat_stop_ms;
      logic [15:0] sample_period_ms;
      logic [11:0] rise_threshold;
      logic [13:0] delay_start_us;
      logic [13:0] delay_step_us;
      logic [13:0] delay_limit_us;
   } cfg_type;

   typedef struct packed {
      logic        run_enable;
      logic [31:0] now_ms;
      logic [11:0] temp_quarter_deg;
      logic [1:0]  key_code;
   } item_type;

   typedef struct packed {
      logic        pump_enable;
      logic        heater_on;
      logic        fan_on;
      logic [13:0] firing_delay_us;
      logic [1:0]  mode_now;
      logic [11:0] last_run_temp;
   } result_type;

endpackage

// ----- rtl/thpts_csr.sv -----
// ----------------------------------------------------------------------------
// Sequencer configuration registers
// APB-style register file holding the run timing, sampling and delay settings.
// ----------------------------------------------------------------------------
module thpts_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [thpts_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [thpts_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [thpts_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output thpts_pkg::cfg_type                    cfg
);

   thpts_pkg::cfg_type cfg_ff;
   thpts_pkg::cfg_type cfg_in;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            thpts_pkg::REG_RUN_LENGTH:  cfg_in.run_length_ms    = csr_pwdata[23:0];
            thpts_pkg::REG_HEAT_START:  cfg_in.heat_start_ms    = csr_pwdata[23:0];
            thpts_pkg::REG_HEAT_STOP:   cfg_in.heat_stop_ms     = csr_pwdata[23:0];
            thpts_pkg::REG_SAMPLE_PER:  cfg_in.sample_period_ms = csr_pwdata[15:0];
            thpts_pkg::REG_RISE_THRESH: cfg_in.rise_threshold   = csr_pwdata[11:0];
            thpts_pkg::REG_DELAY_START: cfg_in.delay_start_us   = csr_pwdata[13:0];
            thpts_pkg::REG_DELAY_STEP:  cfg_in.delay_step_us    = csr_pwdata[13:0];
            thpts_pkg::REG_DELAY_LIMIT: cfg_in.delay_limit_us   = csr_pwdata[13:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         thpts_pkg::REG_RUN_LENGTH:  csr_prdata = {8'd0, cfg_ff.run_length_ms};
         thpts_pkg::REG_HEAT_START:  csr_prdata = {8'd0, cfg_ff.heat_start_ms};
         thpts_pkg::REG_HEAT_STOP:   csr_prdata = {8'd0, cfg_ff.heat_stop_ms};
         thpts_pkg::REG_SAMPLE_PER:  csr_prdata = {16'd0, cfg_ff.sample_period_ms};
         thpts_pkg::REG_RISE_THRESH: csr_prdata = {20'd0, cfg_ff.rise_threshold};
         thpts_pkg::REG_DELAY_START: csr_prdata = {18'd0, cfg_ff.delay_start_us};
         thpts_pkg::REG_DELAY_STEP:  csr_prdata = {18'd0, cfg_ff.delay_step_us};
         thpts_pkg::REG_DELAY_LIMIT: csr_prdata = {18'd0, cfg_ff.delay_limit_us};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_length_ms    <= thpts_pkg::RST_RUN_LENGTH;
         cfg_ff.heat_start_ms    <= thpts_pkg::RST_HEAT_START;
         cfg_ff.heat_stop_ms     <= thpts_pkg::RST_HEAT_STOP;
         cfg_ff.sample_period_ms <= thpts_pkg::RST_SAMPLE_PER;
         cfg_ff.rise_threshold   <= thpts_pkg::RST_RISE_THRESH;
         cfg_ff.delay_start_us   <= thpts_pkg::RST_DELAY_START;
         cfg_ff.delay_step_us    <= thpts_pkg::RST_DELAY_STEP;
         cfg_ff.delay_limit_us   <= thpts_pkg::RST_DELAY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/thpts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sequencer control pass
// Mode machine, run timing, heater window and dynamic delay stepping.
// ----------------------------------------------------------------------------
module thpts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   commit,
   input  thpts_pkg::item_type    item,
   input  thpts_pkg::cfg_type     cfg,
   output thpts_pkg::result_type  result
);

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] run_start_ff, run_start_in;
   logic        start_taken_ff, start_taken_in;
   logic [13:0] delay_ff, delay_in;
   logic        pump_ff, pump_in;
   logic        heater_ff, heater_in;
   logic        fan_ff, fan_in;
   logic [11:0] ref_temp_ff, ref_temp_in;
   logic [31:0] ref_sample_ff, ref_sample_in;
   logic [11:0] cap_temp_ff, cap_temp_in;

   logic [31:0] run_origin;
   logic [31:0] elapsed;
   logic [31:0] since_sample;
   logic        in_run;
   logic        past_heat_start;
   logic        before_heat_stop;
   logic        take_sample;
   logic [11:0] ref_used;
   logic [12:0] rise_bound;
   logic        rise_hit;
   logic        is_test;

   // A fresh run measures time from this very pass.
   assign run_origin       = start_taken_ff ? run_start_ff : item.now_ms;
   assign elapsed          = item.now_ms - run_origin;
   assign since_sample     = item.now_ms - ref_sample_ff;
   assign in_run           = elapsed <= {8'd0, cfg.run_length_ms};
   assign past_heat_start  = elapsed >= {8'd0, cfg.heat_start_ms};
   assign before_heat_stop = elapsed <= {8'd0, cfg.heat_stop_ms};
   assign take_sample      = since_sample >= {16'd0, cfg.sample_period_ms};
   assign ref_used         = take_sample ? item.temp_quarter_deg : ref_temp_ff;
   // temp - ref >= threshold, rearranged to stay unsigned.
   assign rise_bound       = {1'b0, ref_used} + {1'b0, cfg.rise_threshold};
   assign rise_hit         = {1'b0, item.temp_quarter_deg} >= rise_bound;
   assign is_test          = (mode_ff == thpts_pkg::MODE_CONST)
                          || (mode_ff == thpts_pkg::MODE_DYN);

   always_comb begin
      mode_in        = mode_ff;
      run_start_in   = run_start_ff;
      start_taken_in = start_taken_ff;
      delay_in       = delay_ff;
      pump_in        = pump_ff;
      heater_in      = heater_ff;
      fan_in         = fan_ff;
      ref_temp_in    = ref_temp_ff;
      ref_sample_in  = ref_sample_ff;
      cap_temp_in    = cap_temp_ff;
      if (item.run_enable) begin
         if (mode_ff == thpts_pkg::MODE_IDLE) begin
            pump_in        = 1'b0;
            start_taken_in = 1'b0;
            fan_in         = 1'b0;
            if (item.key_code == thpts_pkg::KEY_ONE) begin
               mode_in = thpts_pkg::MODE_CONST;
            end else if (item.key_code == thpts_pkg::KEY_TWO) begin
               mode_in = thpts_pkg::MODE_DYN;
            end
         end else if (is_test) begin
            fan_in         = 1'b1;
            start_taken_in = 1'b1;
            run_start_in   = run_origin;
            if (mode_ff == thpts_pkg::MODE_CONST) begin
               delay_in = cfg.delay_start_us;
            end
            if (in_run) begin
               pump_in = 1'b1;
               if (mode_ff == thpts_pkg::MODE_CONST) begin
                  heater_in = past_heat_start && before_heat_stop;
               end else if (past_heat_start) begin
                  heater_in = before_heat_stop;
                  if (take_sample) begin
                     ref_temp_in   = item.temp_quarter_deg;
                     ref_sample_in = item.now_ms;
                  end
                  if (rise_hit) begin
                     delay_in = (delay_ff > cfg.delay_step_us)
                              ? delay_ff - cfg.delay_step_us : 14'd0;
                  end
               end
            end else begin
               pump_in     = 1'b0;
               mode_in     = thpts_pkg::MODE_IDLE;
               cap_temp_in = item.temp_quarter_deg;
            end
            if (item.key_code == thpts_pkg::KEY_CANCEL) begin
               mode_in = thpts_pkg::MODE_IDLE;
            end
         end else begin
            mode_in = thpts_pkg::MODE_IDLE;
         end
      end
   end

   always_comb begin
      result.pump_enable     = pump_in;
      result.heater_on       = heater_in;
      result.fan_on          = fan_in;
      result.firing_delay_us = (delay_in < cfg.delay_limit_us) ? delay_in
                                                               : cfg.delay_limit_us;
      result.mode_now        = mode_in;
      result.last_run_temp   = cap_temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= thpts_pkg::MODE_IDLE;
         run_start_ff   <= '0;
         start_taken_ff <= 1'b0;
         delay_ff       <= thpts_pkg::RST_FIRING_DLY;
         pump_ff        <= 1'b0;
         heater_ff      <= 1'b0;
         fan_ff         <= 1'b0;
         ref_temp_ff    <= '0;
         ref_sample_ff  <= '0;
         cap_temp_ff    <= '0;
      end else if (commit) begin
         mode_ff        <= mode_in;
         run_start_ff   <= run_start_in;
         start_taken_ff <= start_taken_in;
         delay_ff       <= delay_in;
         pump_ff        <= pump_in;
         heater_ff      <= heater_in;
         fan_ff         <= fan_in;
         ref_temp_ff    <= ref_temp_in;
         ref_sample_ff  <= ref_sample_in;
         cap_temp_ff    <= cap_temp_in;
      end
   end

`ifndef ASSERT_OFF
   // The pump only runs inside a test, so it never runs with the fan off.
   a_pump_needs_fan: assert property (@(posedge clock) disable iff (reset)
      pump_ff |-> fan_ff)
      else $error("pump on while fan off");

   // An idle pass always switches the pump and fan off.
   a_idle_pass_off: assert property (@(posedge clock) disable iff (reset)
      commit && item.run_enable && (mode_ff == thpts_pkg::MODE_IDLE)
      |=> !pump_ff && !fan_ff && !start_taken_ff)
      else $error("idle pass left pump or fan on");

   // State never moves without a committed pass.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(mode_ff) && $stable(delay_ff) && $stable(cap_temp_ff))
      else $error("state changed without a pass");
`endif

endmodule

// ----- rtl/timed_heat_pump_test_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Timed heat pump test sequencer core
// Input stage, control pass and result register around the test sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  req_     | in        | req_valid / req_ready | run_enable, now_ms, temp, key
//  rsp_     | out       | rsp_valid / rsp_ready | pump, heater, fan, delay, mode,
//           |           |                       | last_run_temp
//  csr_     | in/out    | APB psel/penable      | eight setting registers
//
//  A beat is registered in the input stage, processed in one pass of logic and
//  written to the result register, which offers it on the response channel;
//  one beat per cycle is sustained while rsp_ready stays high. Reset is synchronous and
//  leaves both stages empty.
//  When the result register is held by rsp_ready low, the input stage keeps
//  one more beat and then drops req_ready.
// ----------------------------------------------------------------------------
module timed_heat_pump_test_sequencer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_run_enable,
   input  logic [31:0]                           req_now_ms,
   input  logic [11:0]                           req_temp_quarter_deg,
   input  logic [1:0]                            req_key_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_pump_enable,
   output logic                                  rsp_heater_on,
   output logic                                  rsp_fan_on,
   output logic [13:0]                           rsp_firing_delay_us,
   output logic [1:0]                            rsp_mode_now,
   output logic [11:0]                           rsp_last_run_temp,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [thpts_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [thpts_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [thpts_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   thpts_pkg::cfg_type    cfg;
   thpts_pkg::item_type   stage_ff, stage_in;
   logic                  stage_valid_ff, stage_valid_in;
   thpts_pkg::result_type pass_result;
   thpts_pkg::result_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  req_take;

   thpts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   thpts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (stage_ff),
      .cfg    (cfg),
      .result (pass_result)
   );

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_in.run_enable       = req_run_enable;
         stage_in.now_ms           = req_now_ms;
         stage_in.temp_quarter_deg = req_temp_quarter_deg;
         stage_in.key_code         = req_key_code;
         stage_valid_in            = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = pass_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pump_enable     = rsp_ff.pump_enable;
   assign rsp_heater_on       = rsp_ff.heater_on;
   assign rsp_fan_on          = rsp_ff.fan_on;
   assign rsp_firing_delay_us = rsp_ff.firing_delay_us;
   assign rsp_mode_now        = rsp_ff.mode_now;
   assign rsp_last_run_temp   = rsp_ff.last_run_temp;

`ifndef ASSERT_OFF
   // The reported delay never exceeds the configured limit.
   a_delay_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.firing_delay_us <= cfg.delay_limit_us)
      else $error("reported delay above limit");

   // A held input beat is not lost while the result side stalls.
   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !advance |=> stage_valid_ff && $stable(stage_ff))
      else $error("input stage dropped a stalled beat");

   // A pass is only committed into a free or draining result register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result overwritten while stalled");
`endif

endmodule

// ----- dv/timed_heat_pump_test_sequencer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed heat pump test sequencer core testbench
// Drives control passes through the request channel and checks every beat on
// the response channel against a cycle-free model of the sequencer or, for some
// directed rows, a typed result. The run starts with a short directed list, then moves through phases of register
// settings (all zero, all ones, random). Each phase holds mostly complete test
// runs with random timing and temperature, plus some malformed traffic.
// ----------------------------------------------------------------------------
module timed_heat_pump_test_sequencer_core_tb;

   localparam int unsigned ITEM_GOAL   = 1950;
   localparam int unsigned PHASES      = 14;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned LONG_HOLD   = 64;
   localparam int unsigned SETTLE      = 4;

   typedef struct {
      thpts_pkg::item_type   pass_in;
      bit                    pin;
      thpts_pkg::result_type want;
   } directed_pass_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_run_enable;
   logic [31:0]                         req_now_ms;
   logic [11:0]                         req_temp_quarter_deg;
   logic [1:0]                          req_key_code;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic                                rsp_pump_enable;
   logic                                rsp_heater_on;
   logic                                rsp_fan_on;
   logic [13:0]                         rsp_firing_delay_us;
   logic [1:0]                          rsp_mode_now;
   logic [11:0]                         rsp_last_run_temp;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [thpts_pkg::CsrAddrWidth-1:0]  csr_paddr;
   logic [thpts_pkg::CsrDataWidth-1:0]  csr_pwdata;
   logic [thpts_pkg::CsrDataWidth-1:0]  csr_prdata;
   logic                                csr_pready;

   // Model state and its copy of the registers.
   thpts_pkg::cfg_type cfg;
   logic [1:0]  st_mode;
   logic [31:0] st_run_start;
   logic        st_started;
   logic [13:0] st_delay;
   logic        st_pump;
   logic        st_heater;
   logic        st_fan;
   logic [11:0] st_ref_temp;
   logic [31:0] st_ref_time;
   logic [11:0] st_captured;

   thpts_pkg::result_type pass_outputs_q[$];
   directed_pass_type     directed_q[$];
   bit                    pin_on;
   thpts_pkg::result_type pin_want;
   bit                    calm;
   bit                    hold_rsp;
   int unsigned           driven_passes;
   int unsigned           fault_count;
   int unsigned           beat_no;
   int unsigned           cycle_count = 0;

   timed_heat_pump_test_sequencer_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_run_enable       (req_run_enable),
      .req_now_ms           (req_now_ms),
      .req_temp_quarter_deg (req_temp_quarter_deg),
      .req_key_code         (req_key_code),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pump_enable      (rsp_pump_enable),
      .rsp_heater_on        (rsp_heater_on),
      .rsp_fan_on           (rsp_fan_on),
      .rsp_firing_delay_us  (rsp_firing_delay_us),
      .rsp_mode_now         (rsp_mode_now),
      .rsp_last_run_temp    (rsp_last_run_temp),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int unsigned idle_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
   endfunction

   // One control pass of the sequencer: updates the model state and returns
   // the outputs that the pass leaves behind.
   task automatic sequencer_pass(input thpts_pkg::item_type it,
                                 output thpts_pkg::result_type r);
      logic [31:0]        elapsed;
      logic [31:0]        since_sample;
      logic signed [13:0] rise;
      if (it.run_enable) begin
         if (st_mode == thpts_pkg::MODE_IDLE) begin
            st_pump    = 1'b0;
            st_started = 1'b0;
            st_fan     = 1'b0;
            if (it.key_code == thpts_pkg::KEY_ONE)
               st_mode = thpts_pkg::MODE_CONST;
            else if (it.key_code == thpts_pkg::KEY_TWO)
               st_mode = thpts_pkg::MODE_DYN;
         end else if (st_mode == thpts_pkg::MODE_CONST || st_mode == thpts_pkg::MODE_DYN) begin
            st_fan = 1'b1;
            if (!st_started) begin
               st_run_start = it.now_ms;
               st_started   = 1'b1;
            end
            if (st_mode == thpts_pkg::MODE_CONST)
               st_delay = cfg.delay_start_us;
            elapsed = it.now_ms - st_run_start;
            if (elapsed <= {8'd0, cfg.run_length_ms}) begin
               st_pump = 1'b1;
               if (st_mode == thpts_pkg::MODE_CONST) begin
                  st_heater = (elapsed >= {8'd0, cfg.heat_start_ms}) &&
                              (elapsed <= {8'd0, cfg.heat_stop_ms});
               end else if (elapsed >= {8'd0, cfg.heat_start_ms}) begin
                  st_heater    = (elapsed <= {8'd0, cfg.heat_stop_ms});
                  since_sample = it.now_ms - st_ref_time;
                  if (since_sample >= {16'd0, cfg.sample_period_ms}) begin
                     st_ref_temp = it.temp_quarter_deg;
                     st_ref_time = it.now_ms;
                  end
                  rise = $signed({2'b00, it.temp_quarter_deg}) - $signed({2'b00, st_ref_temp});
                  if (rise >= $signed({2'b00, cfg.rise_threshold})) begin
                     st_delay = (st_delay > cfg.delay_step_us) ?
                                st_delay - cfg.delay_step_us : 14'd0;
                  end
               end
            end else begin
               // Run timed out: the last temperature is kept for the report.
               st_pump     = 1'b0;
               st_mode     = thpts_pkg::MODE_IDLE;
               st_captured = it.temp_quarter_deg;
            end
            if (it.key_code == thpts_pkg::KEY_CANCEL)
               st_mode = thpts_pkg::MODE_IDLE;
         end else begin
            st_mode = thpts_pkg::MODE_IDLE;
         end
      end
      r.pump_enable     = st_pump;
      r.heater_on       = st_heater;
      r.fan_on          = st_fan;
      r.firing_delay_us = (st_delay < cfg.delay_limit_us) ? st_delay : cfg.delay_limit_us;
      r.mode_now        = st_mode;
      r.last_run_temp   = st_captured;
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         if (fault_count < 10)
            $display("beat %0d: %s expected %0d, got %0d", beat_no, name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      thpts_pkg::item_type   pass_in;
      thpts_pkg::result_type calc;
      thpts_pkg::result_type got;
      thpts_pkg::result_type want;
      if (!reset && req_valid && req_ready) begin
         pass_in = {req_run_enable, req_now_ms, req_temp_quarter_deg, req_key_code};
         sequencer_pass(pass_in, calc);
         pass_outputs_q.push_back(pin_on ? pin_want : calc);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_pump_enable, rsp_heater_on, rsp_fan_on, rsp_firing_delay_us,
                rsp_mode_now, rsp_last_run_temp};
         if (pass_outputs_q.size() == 0) begin
            if (fault_count < 10)
               $display("beat %0d: result beat with nothing outstanding", beat_no);
            fault_count++;
         end else begin
            want = pass_outputs_q.pop_front();
            check_field("pump_enable", want.pump_enable, got.pump_enable);
            check_field("heater_on", want.heater_on, got.heater_on);
            check_field("fan_on", want.fan_on, got.fan_on);
            check_field("firing_delay_us", want.firing_delay_us, got.firing_delay_us);
            check_field("mode_now", want.mode_now, got.mode_now);
            check_field("last_run_temp", want.last_run_temp, got.last_run_temp);
         end
         beat_no++;
      end
   end

   // Response side: random stalls, plus one long hold-off when asked for.
   initial begin : receiver
      int unsigned n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            n = LONG_HOLD;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = idle_len();
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 12);
         end
         repeat (n - 1) @(posedge clock);
      end
   end

   task automatic offer(input thpts_pkg::item_type it, input bit pin,
                        input thpts_pkg::result_type want);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_run_enable       <= it.run_enable;
      req_now_ms           <= it.now_ms;
      req_temp_quarter_deg <= it.temp_quarter_deg;
      req_key_code         <= it.key_code;
      pin_on               <= pin;
      pin_want             <= want;
      do @(posedge clock); while (!req_ready);
      if (it.run_enable)
         driven_passes++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pass_outputs_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         thpts_pkg::REG_RUN_LENGTH:  cfg.run_length_ms    = val[23:0];
         thpts_pkg::REG_HEAT_START:  cfg.heat_start_ms    = val[23:0];
         thpts_pkg::REG_HEAT_STOP:   cfg.heat_stop_ms     = val[23:0];
         thpts_pkg::REG_SAMPLE_PER:  cfg.sample_period_ms = val[15:0];
         thpts_pkg::REG_RISE_THRESH: cfg.rise_threshold   = val[11:0];
         thpts_pkg::REG_DELAY_START: cfg.delay_start_us   = val[13:0];
         thpts_pkg::REG_DELAY_STEP:  cfg.delay_step_us    = val[13:0];
         thpts_pkg::REG_DELAY_LIMIT: cfg.delay_limit_us   = val[13:0];
         default: ;
      endcase
   endtask

   task automatic plan(input logic en, input logic [31:0] now, input logic [11:0] temp,
                       input logic [1:0] key, input bit pin,
                       input thpts_pkg::result_type want);
      directed_pass_type row;
      row.pass_in = {en, now, temp, key};
      row.pin     = pin;
      row.want    = want;
      directed_q.push_back(row);
   endtask

   initial begin : stimulus
      thpts_pkg::item_type it;
      logic [31:0]       now;
      logic [31:0]       val;
      logic [31:0]       stride;
      longint unsigned   offset;
      longint unsigned   span;
      int                temp;
      int unsigned       roll;
      int unsigned       goal;
      int unsigned       steps;
      int                phase;
      int                r;
      bit                ended;

      reset                = 1'b1;
      req_valid            = 1'b0;
      req_run_enable       = 1'b0;
      req_now_ms           = '0;
      req_temp_quarter_deg = '0;
      req_key_code         = thpts_pkg::KEY_NONE;
      rsp_ready            = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      pin_on               = 1'b0;
      pin_want             = '0;
      calm                 = 1'b0;
      hold_rsp             = 1'b0;
      driven_passes        = 0;
      fault_count          = 0;
      beat_no              = 0;
      cfg = {thpts_pkg::RST_RUN_LENGTH, thpts_pkg::RST_HEAT_START, thpts_pkg::RST_HEAT_STOP,
             thpts_pkg::RST_SAMPLE_PER, thpts_pkg::RST_RISE_THRESH,
             thpts_pkg::RST_DELAY_START, thpts_pkg::RST_DELAY_STEP,
             thpts_pkg::RST_DELAY_LIMIT};
      st_mode      = thpts_pkg::MODE_IDLE;
      st_run_start = '0;
      st_started   = 1'b0;
      st_delay     = thpts_pkg::RST_FIRING_DLY;
      st_pump      = 1'b0;
      st_heater    = 1'b0;
      st_fan       = 1'b0;
      st_ref_temp  = '0;
      st_ref_time  = '0;
      st_captured  = '0;

      // Directed list under the reset settings. Rows with a typed result are
      // the ones whose outputs follow directly from reset, extremes, a timeout or
      // the dynamic delay stepping down to zero; the rest go through the model.
      plan(1'b0, 32'd0, 12'd0, thpts_pkg::KEY_ONE, 1'b1,
           {1'b0, 1'b0, 1'b0, 14'd2500, thpts_pkg::MODE_IDLE, 12'd0});
      plan(1'b1, 32'hFFFF_FFFF, 12'd4095, thpts_pkg::KEY_NONE, 1'b1,
           {1'b0, 1'b0, 1'b0, 14'd2500, thpts_pkg::MODE_IDLE, 12'd0});
      plan(1'b1, 32'd0, 12'd0, thpts_pkg::KEY_CANCEL, 1'b1,
           {1'b0, 1'b0, 1'b0, 14'd2500, thpts_pkg::MODE_IDLE, 12'd0});
      plan(1'b1, 32'd1000, 12'd100, thpts_pkg::KEY_ONE, 1'b1,
           {1'b0, 1'b0, 1'b0, 14'd2500, thpts_pkg::MODE_CONST, 12'd0});
      // The run starts just before the time counter wraps.
      plan(1'b1, 32'hFFFF_FFF0, 12'd200, thpts_pkg::KEY_TWO, 1'b1,
           {1'b1, 1'b0, 1'b1, 14'd2500, thpts_pkg::MODE_CONST, 12'd0});
      plan(1'b1, 32'd19984, 12'd300, thpts_pkg::KEY_NONE, 1'b1,
           {1'b1, 1'b1, 1'b1, 14'd2500, thpts_pkg::MODE_CONST, 12'd0});
      plan(1'b0, 32'd5, 12'd4095, thpts_pkg::KEY_CANCEL, 1'b0, '0);
      plan(1'b1, 32'd49984, 12'd300, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd49985, 12'd300, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd109984, 12'd300, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd109985, 12'd4095, thpts_pkg::KEY_NONE, 1'b1,
           {1'b0, 1'b0, 1'b1, 14'd2500, thpts_pkg::MODE_IDLE, 12'd4095});
      plan(1'b1, 32'd5000, 12'd0, thpts_pkg::KEY_TWO, 1'b1,
           {1'b0, 1'b0, 1'b0, 14'd2500, thpts_pkg::MODE_DYN, 12'd4095});
      plan(1'b1, 32'd5000, 12'd10, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd25000, 12'd10, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd26000, 12'd11, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd27000, 12'd0, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd28000, 12'd50, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd28100, 12'd60, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd28200, 12'd60, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd28300, 12'd60, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd28400, 12'd60, thpts_pkg::KEY_NONE, 1'b0, '0);
      plan(1'b1, 32'd28500, 12'd60, thpts_pkg::KEY_NONE, 1'b1,
           {1'b1, 1'b1, 1'b1, 14'd0, thpts_pkg::MODE_DYN, 12'd4095});
      plan(1'b1, 32'd28600, 12'd60, thpts_pkg::KEY_CANCEL, 1'b1,
           {1'b1, 1'b1, 1'b1, 14'd0, thpts_pkg::MODE_IDLE, 12'd4095});
      plan(1'b1, 32'd0, 12'd0, thpts_pkg::KEY_NONE, 1'b1,
           {1'b0, 1'b1, 1'b0, 14'd0, thpts_pkg::MODE_IDLE, 12'd4095});
      plan(1'b1, 32'd100, 12'd0, thpts_pkg::KEY_ONE, 1'b0, '0);
      plan(1'b1, 32'd200, 12'd0, thpts_pkg::KEY_NONE, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i])
         offer(directed_q[i].pass_in, directed_q[i].pin, directed_q[i].want);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         calm = (phase == 3 || phase == 8 || phase == 12);
         // While the response side holds off, the request side keeps offering
         // back to back so that both stages fill and req_ready drops.
         hold_rsp = (phase == 3);
         for (r = 0; r < 8; r++) begin
            case (phase)
               1: val = '0;
               2: val = '1;
               default:
                  case (r)
                     thpts_pkg::REG_RUN_LENGTH:
                        val = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
                     thpts_pkg::REG_HEAT_START:  val = $urandom_range(0, 1500);
                     thpts_pkg::REG_HEAT_STOP:   val = $urandom_range(0, 3000);
                     thpts_pkg::REG_SAMPLE_PER:
                        val = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
                     thpts_pkg::REG_RISE_THRESH:
                        val = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12);
                     default:         val = $urandom;
                  endcase
            endcase
            csr_write(r[2:0], val);
         end

         goal = (phase + 1) * ITEM_GOAL / PHASES;
         while (driven_passes < goal) begin
            if ($urandom_range(0, 9) == 0) begin
               // Malformed traffic: passes with random enable, time and keys.
               repeat ($urandom_range(1, 4)) begin
                  it.run_enable       = 1'($urandom_range(0, 1));
                  it.now_ms           = $urandom;
                  it.temp_quarter_deg = 12'($urandom_range(0, 4095));
                  it.key_code         = 2'($urandom_range(0, 3));
                  offer(it, 1'b0, '0);
               end
            end else begin
               roll = $urandom_range(0, 9);
               now  = (roll < 3) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) :
                      (roll == 3) ? 32'd0 : $urandom;
               temp = $urandom_range(0, 4095);
               span = cfg.run_length_ms;
               it.run_enable       = 1'b1;
               it.now_ms           = $urandom;
               it.temp_quarter_deg = temp[11:0];
               it.key_code         = $urandom_range(0, 1) ? thpts_pkg::KEY_ONE
                                                          : thpts_pkg::KEY_TWO;
               offer(it, 1'b0, '0);
               offset = 0;
               steps  = 0;
               ended  = 1'b0;
               while (!ended) begin
                  it.run_enable       = (steps == 0) || ($urandom_range(0, 19) != 0);
                  it.now_ms           = now;
                  it.temp_quarter_deg = temp[11:0];
                  roll = $urandom_range(0, 99);
                  it.key_code = (roll < 3) ? thpts_pkg::KEY_CANCEL :
                                (roll < 6) ? thpts_pkg::KEY_ONE :
                                (roll < 8) ? thpts_pkg::KEY_TWO : thpts_pkg::KEY_NONE;
                  offer(it, 1'b0, '0);
                  ended = (it.run_enable &&
                           (offset > span || it.key_code == thpts_pkg::KEY_CANCEL)) ||
                          steps >= 80;
                  roll   = $urandom_range(0, 99);
                  stride = (roll < 4) ? $urandom : (roll < 10) ? 32'd0 :
                           $urandom_range(1, 32'(span / 6 + 2));
                  now    = now + stride;
                  offset = offset + stride;
                  steps++;
                  if ($urandom_range(0, 19) == 0)
                     temp = $urandom_range(0, 4095);
                  else
                     temp = temp + int'($urandom_range(0, 6)) - 2;
                  if (temp < 0)
                     temp = 0;
                  if (temp > 4095)
                     temp = 4095;
               end
            end
         end
      end

      calm = 1'b0;
      wait_drained();
      if (fault_count == 0 && pass_outputs_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/thpts_pkg.sv
rtl/thpts_csr.sv
rtl/thpts_ctrl.sv
rtl/timed_heat_pump_test_sequencer_core.sv
dv/timed_heat_pump_test_sequencer_core_tb.sv
